[hdl/fpla_pkg.sv]
// Free page list allocator: shared types and constants.
// No dependencies.
`default_nettype none

package fpla_pkg;

    localparam int PAGE_W = 10;
    localparam int CNT_W  = 11;
    localparam int ST_W   = 3;
    localparam int FN_W   = 2;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 11'd1024;

    localparam logic [FN_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FN_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FN_W-1:0] FN_QUERY = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_FREE     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FREE = 3'd3;
    localparam logic [ST_W-1:0] ST_ALREADY  = 3'd4;
    localparam logic [ST_W-1:0] ST_ERROR    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_ALLOC = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    typedef struct packed {
        logic is_zero;
        logic in_range;
        logic hit;
        logic over;
    } t_chk;

endpackage

`default_nettype wire

[hdl/free_page_list_allocator_core.sv]
// Free page list allocator top level: sequencer, link memory, result register.
// Depends on fpla_pkg and fpla_check.
//
// channel   direction  handshake                  payload
// in        request    i_in_valid / o_in_stall    i_func, i_page
// out       result     o_out_valid / i_out_stall  o_status, o_got_page
// cfg       write      i_cfg_we                   i_cfg_wdata (page_count)
//
// One request at a time. Allocate goes through S_ALLOC to S_OUT; a rejected
// request goes straight to S_OUT. Free and query walk the list at one link
// read per cycle through the registered memory port.
// Synchronous active-low reset empties the list and sets page_count to 1024.
// A held result does not block the next request; only the final hand-off waits.
`default_nettype none

module free_page_list_allocator_core #(
    parameter int PAGES = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [fpla_pkg::FN_W-1:0]      i_func,
    input  wire logic [fpla_pkg::PAGE_W-1:0]    i_page,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [fpla_pkg::ST_W-1:0]           o_status,
    output logic [fpla_pkg::PAGE_W-1:0]         o_got_page,
    input  wire logic                           i_cfg_we,
    input  wire logic [fpla_pkg::CNT_W-1:0]     i_cfg_wdata
);

    localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int XW = (AW > fpla_pkg::PAGE_W) ? AW : fpla_pkg::PAGE_W;

    function automatic logic [AW-1:0] to_addr(input logic [fpla_pkg::PAGE_W-1:0] p);
        logic [XW-1:0] e;
        e = XW'(p);
        return e[AW-1:0];
    endfunction

    fpla_pkg::t_state r_state, n_state;
    logic [fpla_pkg::CNT_W-1:0]  r_page_count;
    logic [fpla_pkg::PAGE_W-1:0] r_head, n_head;
    logic [fpla_pkg::PAGE_W-1:0] r_page, n_page;
    logic [fpla_pkg::FN_W-1:0]   r_func, n_func;
    logic                        r_first, n_first;
    logic [fpla_pkg::CNT_W-1:0]  r_vis, n_vis;
    logic [fpla_pkg::ST_W-1:0]   r_res_st, n_res_st;
    logic [fpla_pkg::PAGE_W-1:0] r_res_got, n_res_got;
    logic                        r_out_valid;
    logic [fpla_pkg::ST_W-1:0]   r_out_status;
    logic [fpla_pkg::PAGE_W-1:0] r_out_got;

    logic [fpla_pkg::PAGE_W-1:0] mem [PAGES];
    logic [fpla_pkg::PAGE_W-1:0] r_rdata;

    logic                        w_acc;
    logic                        w_out_free;
    logic [fpla_pkg::PAGE_W-1:0] w_cur;
    logic                        w_we;
    logic [AW-1:0]               w_wa;
    logic [fpla_pkg::PAGE_W-1:0] w_wd;
    fpla_pkg::t_chk              w_chk;

    assign w_acc       = i_in_valid && (r_state == fpla_pkg::S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != fpla_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_got_page  = r_out_got;

    always_comb begin
        if (r_state == fpla_pkg::S_WALK) begin
            w_cur = r_first ? r_head : r_rdata;
        end else if (r_state == fpla_pkg::S_IDLE && i_func != fpla_pkg::FN_ALLOC) begin
            w_cur = i_page;
        end else begin
            w_cur = r_head;
        end
    end

    fpla_check #(
        .PAGES(PAGES)
    ) u_check (
        .i_cur        (w_cur),
        .i_page       (r_page),
        .i_visited    (r_vis),
        .i_page_count (r_page_count),
        .o_chk        (w_chk)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_page    = r_page;
        n_func    = r_func;
        n_first   = r_first;
        n_vis     = r_vis;
        n_res_st  = r_res_st;
        n_res_got = r_res_got;
        w_we      = 1'b0;
        w_wa      = to_addr(r_head);
        w_wd      = '0;
        case (r_state)
            fpla_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_func    = i_func;
                    n_page    = i_page;
                    n_res_got = '0;
                    n_first   = 1'b1;
                    n_vis     = '0;
                    n_res_st  = fpla_pkg::ST_ERROR;
                    n_state   = fpla_pkg::S_OUT;
                    case (i_func)
                        fpla_pkg::FN_ALLOC: begin
                            if (w_chk.is_zero) begin
                                n_res_st = fpla_pkg::ST_EMPTY;
                            end else if (w_chk.in_range) begin
                                n_state = fpla_pkg::S_ALLOC;
                            end
                        end
                        fpla_pkg::FN_FREE: begin
                            if (!w_chk.is_zero && w_chk.in_range) begin
                                n_state = fpla_pkg::S_WALK;
                            end
                        end
                        fpla_pkg::FN_QUERY: begin
                            if (w_chk.in_range) begin
                                n_state = fpla_pkg::S_WALK;
                            end
                        end
                        default: begin
                            n_state = fpla_pkg::S_OUT;
                        end
                    endcase
                end
            end
            fpla_pkg::S_ALLOC: begin
                w_we      = 1'b1;
                w_wa      = to_addr(r_head);
                w_wd      = '0;
                n_head    = r_rdata;
                n_res_got = r_head;
                n_res_st  = fpla_pkg::ST_DONE;
                n_state   = fpla_pkg::S_OUT;
            end
            fpla_pkg::S_WALK: begin
                if (w_chk.is_zero) begin
                    n_state = fpla_pkg::S_OUT;
                    if (r_func == fpla_pkg::FN_QUERY) begin
                        n_res_st = fpla_pkg::ST_NOT_FREE;
                    end else begin
                        w_we     = 1'b1;
                        w_wa     = to_addr(r_page);
                        w_wd     = r_head;
                        n_head   = r_page;
                        n_res_st = fpla_pkg::ST_DONE;
                    end
                end else if (w_chk.over || !w_chk.in_range) begin
                    n_res_st = fpla_pkg::ST_ERROR;
                    n_state  = fpla_pkg::S_OUT;
                end else if (w_chk.hit) begin
                    n_res_st = (r_func == fpla_pkg::FN_QUERY) ? fpla_pkg::ST_FREE
                                                              : fpla_pkg::ST_ALREADY;
                    n_state  = fpla_pkg::S_OUT;
                end else begin
                    n_first = 1'b0;
                    n_vis   = r_vis + 11'd1;
                end
            end
            fpla_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = fpla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpla_pkg::S_IDLE;
            end
        endcase
    end

    // link memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rdata <= mem[to_addr(w_cur)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fpla_pkg::S_IDLE;
            r_head       <= '0;
            r_page_count <= fpla_pkg::PAGE_COUNT_RST;
            r_out_valid  <= 1'b0;
            r_first      <= 1'b0;
            r_vis        <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_first <= n_first;
            r_vis   <= n_vis;
            if (i_cfg_we) begin
                r_page_count <= i_cfg_wdata;
            end
            if (r_state == fpla_pkg::S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_func    <= n_func;
        r_res_st  <= n_res_st;
        r_res_got <= n_res_got;
        if (r_state == fpla_pkg::S_OUT && w_out_free) begin
            r_out_status <= r_res_st;
            r_out_got    <= r_res_got;
        end
    end

`ifndef SYNTHESIS
    a_vis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpla_pkg::S_WALK) |-> (r_vis <= r_page_count))
        else $error("walk step count passed page_count");

    a_got_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_got_page != '0) |-> (o_status == fpla_pkg::ST_DONE))
        else $error("page handed out without done status");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != fpla_pkg::S_IDLE))
        else $error("sequencer idle right after accepting a request");
`endif

endmodule

`default_nettype wire

[hdl/fpla_check.sv]
// Shared page check unit: range check, zero, match and step-limit compare.
// Depends on fpla_pkg.
`default_nettype none

module fpla_check #(
    parameter int PAGES = 1024
) (
    input  wire logic [fpla_pkg::PAGE_W-1:0] i_cur,
    input  wire logic [fpla_pkg::PAGE_W-1:0] i_page,
    input  wire logic [fpla_pkg::CNT_W-1:0]  i_visited,
    input  wire logic [fpla_pkg::CNT_W-1:0]  i_page_count,
    output fpla_pkg::t_chk                   o_chk
);

    localparam logic [16:0] PagesW = 17'(PAGES);

    always_comb begin
        o_chk.is_zero  = (i_cur == '0);
        o_chk.in_range = (fpla_pkg::CNT_W'(i_cur) < i_page_count) && (17'(i_cur) < PagesW);
        o_chk.hit      = (i_cur == i_page);
        o_chk.over     = (i_visited >= i_page_count);
    end

endmodule

`default_nettype wire
